// ----- rtl/i2ctr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C target receiver package
// Shared types and constants for the receiver datapath and its registers.
// ----------------------------------------------------------------------------
package i2ctr_pkg;

	// Configuration register indexes.
	localparam logic REG_OWN_ADDRESS = 1'b0;
	localparam logic REG_DATA_LENGTH = 1'b1;

	localparam logic [6:0] OWN_ADDRESS_RST = 7'h18;
	localparam logic [7:0] DATA_LENGTH_RST = 8'd1;

	// Bus phases of the receiver.
	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_ADDR  = 3'd1;
	localparam logic [2:0] PH_DATA  = 3'd2;
	localparam logic [2:0] PH_ACK   = 3'd3;
	localparam logic [2:0] PH_NOACK = 3'd4;

	localparam logic [3:0] BITS_PER_BYTE = 4'd8;
	localparam logic [3:0] ACK_BIT       = 4'd9;
	localparam logic [7:0] COUNT_MAX     = 8'd255;

	typedef struct packed {
		logic [6:0] own_address;
		logic [7:0] data_length;
	} cfg_t;

	typedef struct packed {
		logic       sda_pull_low;
		logic       byte_valid;
		logic [7:0] byte_value;
		logic       is_address;
		logic       last_byte;
		logic       stop_seen;
	} res_t;

endpackage

// ----- rtl/i2ctr_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C target receiver configuration registers
// Holds the own address and the acknowledged data length.
// ----------------------------------------------------------------------------
module i2ctr_cfg_regs
	import i2ctr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_en,
	input  logic       wr_index,
	input  logic [7:0] wr_data,
	output cfg_t       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.own_address <= OWN_ADDRESS_RST;
			cfg_q.data_length <= DATA_LENGTH_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_OWN_ADDRESS: cfg_q.own_address <= wr_data[6:0];
				REG_DATA_LENGTH: cfg_q.data_length <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/i2ctr_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C target receiver engine
// Bus condition detection, bit shifting, address match and ack control.
// ----------------------------------------------------------------------------
module i2ctr_engine
	import i2ctr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  logic scl,
	input  logic sda,
	input  cfg_t cfg,
	output res_t res
);

	logic       prev_scl_q, prev_sda_q;
	logic [2:0] phase_q, phase_d;
	logic [3:0] bit_count_q, bit_count_d;
	logic [7:0] shift_q, shift_d;
	logic [7:0] bytes_q, bytes_d;
	logic       ack_q, ack_d;

	logic       start, stop, rising, falling;
	logic [7:0] shift_in;
	logic [3:0] count_inc;
	logic       ack_ok;

	assign start   = prev_scl_q & scl & prev_sda_q & ~sda;
	assign stop    = prev_scl_q & scl & ~prev_sda_q & sda;
	assign rising  = ~prev_scl_q & scl;
	assign falling = prev_scl_q & ~scl;

	assign shift_in  = {shift_q[6:0], sda};
	assign count_inc = bit_count_q + 4'd1;
	assign ack_ok    = bytes_q < cfg.data_length;

	always_comb begin
		phase_d     = phase_q;
		bit_count_d = bit_count_q;
		shift_d     = shift_q;
		bytes_d     = bytes_q;
		ack_d       = ack_q;
		res         = '0;

		priority if (start) begin
			phase_d     = PH_ADDR;
			bit_count_d = '0;
			shift_d     = '0;
			bytes_d     = '0;
			ack_d       = 1'b0;
		end else if (stop) begin
			res.stop_seen = (phase_q != PH_IDLE);
			phase_d       = PH_IDLE;
			bit_count_d   = '0;
			shift_d       = '0;
			ack_d         = 1'b0;
		end else if (phase_q == PH_ADDR || phase_q == PH_DATA) begin
			if (rising) begin
				shift_d     = shift_in;
				bit_count_d = count_inc;
				if (count_inc >= BITS_PER_BYTE) begin
					bit_count_d = BITS_PER_BYTE;
					if (phase_q == PH_ADDR) begin
						if (shift_in[7:1] == cfg.own_address) begin
							res.byte_valid = 1'b1;
							res.byte_value = shift_in;
							res.is_address = 1'b1;
							phase_d        = PH_ACK;
						end else begin
							phase_d     = PH_IDLE;
							bit_count_d = '0;
						end
					end else begin
						res.byte_valid = 1'b1;
						res.byte_value = shift_in;
						res.last_byte  = ack_ok &&
							({1'b0, bytes_q} + 9'd1 == {1'b0, cfg.data_length});
						if (bytes_q < COUNT_MAX)
							bytes_d = bytes_q + 8'd1;
						phase_d = ack_ok ? PH_ACK : PH_NOACK;
					end
				end
			end
		end else if (phase_q == PH_ACK || phase_q == PH_NOACK) begin
			if (falling) begin
				if (bit_count_q == BITS_PER_BYTE) begin
					ack_d       = (phase_q == PH_ACK);
					bit_count_d = ACK_BIT;
				end else begin
					ack_d       = 1'b0;
					bit_count_d = '0;
					shift_d     = '0;
					phase_d     = PH_DATA;
				end
			end
		end else begin
			// Idle: everything holds until the next start.
		end

		res.sda_pull_low = ack_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_scl_q  <= 1'b1;
			prev_sda_q  <= 1'b1;
			phase_q     <= PH_IDLE;
			bit_count_q <= '0;
			shift_q     <= '0;
			bytes_q     <= '0;
			ack_q       <= 1'b0;
		end else if (step) begin
			prev_scl_q  <= scl;
			prev_sda_q  <= sda;
			phase_q     <= phase_d;
			bit_count_q <= bit_count_d;
			shift_q     <= shift_d;
			bytes_q     <= bytes_d;
			ack_q       <= ack_d;
		end
	end

endmodule

// ----- rtl/i2c_target_receiver_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C target receiver unit
// The result of an accepted pin sample is registered onto the output.
// Throughput: one sample per cycle; the output register is reloaded in the
// same cycle its result is taken, so only a stalled output holds the input.
// Reset: asynchronous; pins read as idle high, phase idle, drive released,
// own address 0x18 and data length 1, no result pending.
// ----------------------------------------------------------------------------
module i2c_target_receiver_unit
	import i2ctr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // [0] scl_level, [1] sda_level, [7:2] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,    // [0] sda_pull_low, [1] byte_valid,
	                                // [9:2] byte_value, [10] stop_seen, [15:11] zero
	output logic        m_tuser,    // [0] is_address
	output logic        m_tlast,    // last_byte
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);

	cfg_t cfg;
	res_t res;
	res_t res_q;
	logic m_valid_q;
	logic step;

	assign cfg_ready = 1'b1;
	assign s_tready  = ~m_valid_q | m_tready;
	assign step      = s_tvalid & s_tready;

	i2ctr_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	i2ctr_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.scl    (s_tdata[0]),
		.sda    (s_tdata[1]),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s_tready) begin
			m_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (step)
			res_q <= res;
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {5'd0, res_q.stop_seen, res_q.byte_value, res_q.byte_valid,
		res_q.sda_pull_low};
	assign m_tuser  = res_q.is_address;
	assign m_tlast  = res_q.last_byte;

	// A completed byte falls on a rising clock, when the ack drive is released.
	a_byte_no_drive: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && res_q.byte_valid |-> !res_q.sda_pull_low)
		else $error("byte reported while SDA is driven");

	a_last_is_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && res_q.last_byte |-> res_q.byte_valid && !res_q.is_address)
		else $error("last byte flag without a data byte");

	a_stop_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && res_q.stop_seen |-> !res_q.byte_valid)
		else $error("stop and byte in the same result");

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> m_valid_q)
		else $error("accepted sample produced no result");

endmodule
